// File: rtl/core/bgdm_pkg.sv
// Shared types and constants of the BayerGB 12-bit to RGB888 demosaic.
// No dependencies; the pixel sequencer and the top level import this package.
`default_nettype none
package bgdm_pkg;

   localparam int unsigned SAMPLE_W  = 12;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned COLUMN_W  = 12;
   localparam int unsigned WIDTH_W   = 13;
   localparam int unsigned SHIFT_OUT = 4;

   // csr map: one register, byte address 4*index, index taken from paddr[2]
   localparam int unsigned CSR_ADDR_W       = 3;
   localparam int unsigned CSR_DATA_W       = 32;
   localparam logic        CSR_IDX_IMAGE_WIDTH = 1'b0;

   localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd2590;

   // one 2x2 block, ready for the pixel sequencer
   typedef struct packed {
      logic [CHAN_W-1:0]   red;
      logic [CHAN_W-1:0]   green_top;
      logic [CHAN_W-1:0]   green_bottom;
      logic [CHAN_W-1:0]   blue;
      logic [COLUMN_W-1:0] column;      // odd column of the block's right pixel
   } block_type;

   function automatic logic [CHAN_W-1:0] to_chan(input logic [SAMPLE_W-1:0] s);
      to_chan = s[SAMPLE_W-1:SHIFT_OUT];
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/bgdm_line_store.sv
// Line store for the even row of each row pair: one write port and one
// registered read port. Depends on nothing outside this file.
`default_nettype none
module bgdm_line_store #(
   parameter int unsigned DEPTH  = 4096,
   parameter int unsigned ADDR_W = 12,
   parameter int unsigned DATA_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold the read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/bgdm_pixel_seq.sv
// Output sequencer: takes one 2x2 block and hands out its four RGB words in
// the order top-left, top-right, bottom-left, bottom-right. Uses bgdm_pkg.
`default_nettype none
module bgdm_pixel_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire bgdm_pkg::block_type  block,
   output logic                      free,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   output logic [11:0]               rsp_out_column,
   output logic                      rsp_lower_row,
   output logic                      rsp_last
);
   import bgdm_pkg::*;

   localparam logic [1:0] IDX_LAST = 2'd3;

   logic      busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   block_type blk_ff;
   logic      fire;

   assign fire = busy_ff & ~rsp_stall;
   assign free = ~busy_ff | (fire & (idx_ff == IDX_LAST));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end else if (fire) begin
         if (idx_ff == IDX_LAST) begin
            busy_in = 1'b0;
         end
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         blk_ff <= block;
      end
   end

   // bit 0 of the index picks the column, bit 1 the row of the pair
   assign rsp_valid      = busy_ff;
   assign rsp_red        = blk_ff.red;
   assign rsp_blue       = blk_ff.blue;
   assign rsp_green      = idx_ff[0] ? blk_ff.green_bottom : blk_ff.green_top;
   assign rsp_out_column = {blk_ff.column[COLUMN_W-1:1], idx_ff[0]};
   assign rsp_lower_row  = idx_ff[1];
   assign rsp_last       = (idx_ff == IDX_LAST);

endmodule
`default_nettype wire

// File: rtl/core/bayer_gb12_to_rgb888_demosaic.sv
// BayerGB 12-bit to RGB888 nearest-neighbor demosaic, top level.
// A block's first pixel follows its odd-row odd-column word through the assembly and
// sequencer registers. Throughput: one word per cycle in on even rows, if not stalled;
// 4 words out per block, one per cycle unless rsp_stall; odd rows wait on the sequencer.
// Reset (synchronous): column 0, even row, image_width 2590; the line store is not cleared.
// Uses bgdm_pkg, bgdm_line_store and bgdm_pixel_seq.
`default_nettype none
module bayer_gb12_to_rgb888_demosaic #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [11:0] req_sample,
   input  wire logic        req_start_of_frame,
   // result words
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [11:0]      rsp_out_column,
   output logic             rsp_lower_row,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import bgdm_pkg::*;

   localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned WW = 14;
   localparam logic [WW-1:0] MAX_W = WW'(MAX_WIDTH);
   localparam logic [WW-1:0] MIN_W = WW'(2);

   // ---------------- configuration ----------------
   logic [WIDTH_W-1:0] image_width_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == CSR_IDX_IMAGE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
      end else if (csr_wr) begin
         image_width_ff <= csr_pwdata[WIDTH_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_IMAGE_WIDTH)
                       ? {{(CSR_DATA_W-WIDTH_W){1'b0}}, image_width_ff}
                       : '0;

   // effective width: even, at least 2, at most the store depth
   logic [WW-1:0] width_even, width_eff;
   always_comb begin
      width_even = {1'b0, image_width_ff[WIDTH_W-1:1], 1'b0};
      priority if (width_even < MIN_W) begin
         width_eff = MIN_W;
      end else if (width_even > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = width_even;
      end
   end

   // ---------------- raster position ----------------
   logic          accept;
   logic [CW-1:0] col_ff, col_in, col_cur;
   logic          odd_ff, odd_in, odd_cur;
   logic [WW-1:0] col_next;

   assign accept  = req_valid & ~req_stall;
   assign col_cur = req_start_of_frame ? '0 : col_ff;
   assign odd_cur = req_start_of_frame ? 1'b0 : odd_ff;
   assign col_next = WW'(col_cur) + WW'(1);

   always_comb begin
      col_in = col_ff;
      odd_in = odd_ff;
      if (accept) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            odd_in = ~odd_cur;
         end else begin
            col_in = col_next[CW-1:0];
            odd_in = odd_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         odd_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         odd_ff <= odd_in;
      end
   end

   // ---------------- line store ----------------
   logic [SAMPLE_W-1:0] store_rd_data;

   bgdm_line_store #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (CW),
      .DATA_W (SAMPLE_W)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (accept & ~odd_cur),
      .wr_addr    (col_cur),
      .wr_data    (req_sample),
      .rd_en      (accept & odd_cur),
      .rd_addr    (col_cur),
      .rd_data_ff (store_rd_data)
   );

   // ---------------- block assembly stage ----------------
   // red words of an odd row latch red and top green; the green words after them build the block
   logic                b_valid_ff, b_valid_in;
   logic                b_emit_ff;
   logic [SAMPLE_W-1:0] b_sample_ff;
   logic [CW-1:0]       b_col_ff;
   logic [SAMPLE_W-1:0] held_red_ff;
   logic [CHAN_W-1:0]   held_green_ff;
   logic                seq_free;
   logic                seq_load;
   logic [31:0]         b_col_ext;
   block_type           block;

   assign req_stall = b_valid_ff & b_emit_ff & ~seq_free;
   assign seq_load  = b_valid_ff & b_emit_ff & seq_free;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (accept) begin
         b_valid_in = odd_cur;
      end else if (!req_stall) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_emit_ff   <= col_cur[0];
         b_sample_ff <= req_sample;
         b_col_ff    <= col_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_red_ff <= '0;
      end else if (b_valid_ff && !b_emit_ff) begin
         held_red_ff <= b_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff && !b_emit_ff) begin
         held_green_ff <= to_chan(store_rd_data);
      end
   end

   assign b_col_ext = 32'(b_col_ff);

   always_comb begin
      block.red          = to_chan(held_red_ff);
      block.green_top    = held_green_ff;
      block.green_bottom = to_chan(b_sample_ff);
      block.blue         = to_chan(store_rd_data);
      block.column       = b_col_ext[COLUMN_W-1:0];
   end

   // ---------------- output ----------------
   bgdm_pixel_seq u_pixel_seq (
      .clock          (clock),
      .reset          (reset),
      .load           (seq_load),
      .block          (block),
      .free           (seq_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_out_column (rsp_out_column),
      .rsp_lower_row  (rsp_lower_row),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire
